FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define SKT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sorted key table check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define SKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted key table check failed");

`endif

FILE: rtl/skt_pkg.sv
// Shared constants and types of the sorted key table.
package skt_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int KEY_BITS_DEF = 16;

   localparam int KEY_FIELD_W  = 16;
   localparam int HANDLE_W     = 16;
   localparam int REQ_TYPE_W   = 2;
   localparam int STATUS_W     = 2;
   localparam int REQ_FIELDS_W = REQ_TYPE_W + KEY_FIELD_W + HANDLE_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_FIND   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   // Broadcast command to every cell of the row
   typedef struct packed {
      logic ins;
      logic del;
   } cell_cmd_type;

endpackage

FILE: rtl/skt_cell.sv
// One storage cell of the sorted row: compare, hold, or shift left/right.
module skt_cell #(
   parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  skt_pkg::cell_cmd_type       cmd,
   input  logic [KEY_BITS-1:0]         op_key,
   input  logic [skt_pkg::HANDLE_W-1:0] op_handle,
   input  logic                        left_lt,
   input  logic                        left_valid,
   input  logic [KEY_BITS-1:0]         left_key,
   input  logic [skt_pkg::HANDLE_W-1:0] left_handle,
   input  logic                        right_valid,
   input  logic [KEY_BITS-1:0]         right_key,
   input  logic [skt_pkg::HANDLE_W-1:0] right_handle,
   output logic                        valid,
   output logic [KEY_BITS-1:0]         key,
   output logic [skt_pkg::HANDLE_W-1:0] handle,
   output logic                        lt,
   output logic                        eq,
   output logic [skt_pkg::HANDLE_W-1:0] hit_handle
);
   import skt_pkg::*;

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;

   assign lt         = valid_ff && (key_ff < op_key);
   assign eq         = valid_ff && (key_ff == op_key);
   assign hit_handle = eq ? handle_ff : '0;
   assign valid      = valid_ff;
   assign key        = key_ff;
   assign handle     = handle_ff;

   // Cells below the split point hold; the rest open a gap or close one.
   always_comb begin
      valid_in  = valid_ff;
      key_in    = key_ff;
      handle_in = handle_ff;
      if (cmd.ins && !lt) begin
         if (left_lt) begin
            valid_in  = 1'b1;
            key_in    = op_key;
            handle_in = op_handle;
         end else begin
            valid_in  = left_valid;
            key_in    = left_key;
            handle_in = left_handle;
         end
      end else if (cmd.del && !lt) begin
         valid_in  = right_valid;
         key_in    = right_key;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

endmodule

FILE: rtl/sorted_key_table_top.sv
// Top level of the sorted key table: request/response streams and the cell row.
//
// Sorted set of unique keys with a handle each, held in a row of CAPACITY
// cells, lowest key in cell 0. Every cell compares its key with the request
// key at once; a cell then holds, takes its left neighbour (insert) or its
// right neighbour (delete), so the row shifts in a single step.
//
// req channel: one beat per request (insert, delete or find).
// rsp channel: exactly one beat per request, in request order, carrying
//   status, found handle (zero unless a find hits) and the entry count.
// Timing: the request beat is registered in the accept cycle; the compare
//   and shift happen in S_APPLY once the response register is free or
//   being emptied; that update also loads the response register, which
//   drives rsp_tvalid. A new request is taken only after the cell-row
//   update of the last one.
// Stalls: the response register is a one-beat buffer. A next request is
//   still taken while a response waits; its update then holds until the
//   waiting beat is taken, and req_tready stays low meanwhile.
// Reset: synchronous, active high; the table comes up empty (all cells
//   invalid, count zero) with no response pending. No clearing pass.
module sorted_key_table_top #(
   parameter  int CAPACITY = skt_pkg::CAPACITY_DEF,
   parameter  int KEY_BITS = skt_pkg::KEY_BITS_DEF,
   localparam int CNT_W    = $clog2(CAPACITY + 1),
   localparam int RSP_W    = ((skt_pkg::STATUS_W + skt_pkg::HANDLE_W + CNT_W + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: req_type [1:0], key [17:2], item_handle [33:18], zero pad
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [skt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: status [1:0], found_handle [17:2], entry_count above, zero pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata
);
   import skt_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_APPLY
   } state_type;

   state_type             state_ff;
   logic [REQ_TYPE_W-1:0] op_type_ff;
   logic [KEY_BITS-1:0]   op_key_ff;
   logic [HANDLE_W-1:0]   op_handle_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [HANDLE_W-1:0]   rsp_handle_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   // Row wiring: one entry per cell
   logic                c_valid  [CAPACITY];
   logic [KEY_BITS-1:0] c_key    [CAPACITY];
   logic [HANDLE_W-1:0] c_handle [CAPACITY];
   logic                c_lt     [CAPACITY];
   logic                c_eq     [CAPACITY];
   logic [HANDLE_W-1:0] c_hit    [CAPACITY];

   logic                req_beat;
   logic                fire;
   logic                present;
   logic                full;
   logic [HANDLE_W-1:0] hit_handle;
   cell_cmd_type        cmd;
   logic [STATUS_W-1:0] status_in;
   logic [HANDLE_W-1:0] handle_in;
   logic [CNT_W-1:0]    count_in;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   // Update only when the response register is free or being emptied
   assign fire       = (state_ff == S_APPLY) && (!rsp_valid_ff || rsp_tready);
   assign full       = (count_ff == CNT_W'(CAPACITY));

   // Keys are unique, so at most one cell hits: an OR merges them
   always_comb begin
      present    = 1'b0;
      hit_handle = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         present    = present | c_eq[i];
         hit_handle = hit_handle | c_hit[i];
      end
   end

   always_comb begin
      cmd       = '0;
      status_in = ST_MISS;
      handle_in = '0;
      count_in  = count_ff;
      unique case (op_type_ff)
         REQ_INSERT: begin
            if (present) begin
               status_in = ST_MISS;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
               cmd.ins   = fire;
               count_in  = count_ff + CNT_W'(1);
            end
         end
         REQ_DELETE: begin
            if (present) begin
               status_in = ST_OK;
               cmd.del   = fire;
               count_in  = count_ff - CNT_W'(1);
            end
         end
         REQ_FIND: begin
            if (present) begin
               status_in = ST_OK;
               handle_in = hit_handle;
            end
         end
         default: begin
            status_in = ST_MISS;
         end
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                l_lt;
      logic                l_valid;
      logic [KEY_BITS-1:0] l_key;
      logic [HANDLE_W-1:0] l_handle;
      logic                r_valid;
      logic [KEY_BITS-1:0] r_key;
      logic [HANDLE_W-1:0] r_handle;

      if (g == 0) begin : g_left_edge
         // Cell 0 always sees a boundary on its left
         assign l_lt     = 1'b1;
         assign l_valid  = 1'b0;
         assign l_key    = op_key_ff;
         assign l_handle = op_handle_ff;
      end else begin : g_left
         assign l_lt     = c_lt[g-1];
         assign l_valid  = c_valid[g-1];
         assign l_key    = c_key[g-1];
         assign l_handle = c_handle[g-1];
      end

      if (g == CAPACITY - 1) begin : g_right_edge
         assign r_valid  = 1'b0;
         assign r_key    = '0;
         assign r_handle = '0;
      end else begin : g_right
         assign r_valid  = c_valid[g+1];
         assign r_key    = c_key[g+1];
         assign r_handle = c_handle[g+1];
      end

      skt_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .op_key       (op_key_ff),
         .op_handle    (op_handle_ff),
         .left_lt      (l_lt),
         .left_valid   (l_valid),
         .left_key     (l_key),
         .left_handle  (l_handle),
         .right_valid  (r_valid),
         .right_key    (r_key),
         .right_handle (r_handle),
         .valid        (c_valid[g]),
         .key          (c_key[g]),
         .handle       (c_handle[g]),
         .lt           (c_lt[g]),
         .eq           (c_eq[g]),
         .hit_handle   (c_hit[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) begin
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               if (fire) begin
                  state_ff     <= S_IDLE;
                  count_ff     <= count_in;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
      // Payload registers, no reset
      if (req_beat) begin
         op_type_ff   <= req_tdata[REQ_TYPE_W-1:0];
         op_key_ff    <= KEY_BITS'(req_tdata[REQ_TYPE_W +: KEY_FIELD_W]);
         op_handle_ff <= req_tdata[REQ_TYPE_W + KEY_FIELD_W +: HANDLE_W];
      end
      if (fire) begin
         rsp_status_ff <= status_in;
         rsp_handle_ff <= handle_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_count_ff, rsp_handle_ff, rsp_status_ff});

endmodule

FILE: rtl/skt_checker.sv
// Port-level checker for the sorted key table, bound to the top level.
`include "assert_macros.svh"

module skt_checker #(
   parameter  int CAPACITY = skt_pkg::CAPACITY_DEF,
   localparam int CNT_W    = $clog2(CAPACITY + 1),
   localparam int RSP_W    = ((skt_pkg::STATUS_W + skt_pkg::HANDLE_W + CNT_W + 7) / 8) * 8
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [skt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [RSP_W-1:0]                rsp_tdata
);
   import skt_pkg::*;

   logic [STATUS_W-1:0] rsp_status;
   logic [HANDLE_W-1:0] rsp_handle;
   logic [CNT_W-1:0]    rsp_count;
   logic                req_beat;

   assign rsp_status = rsp_tdata[STATUS_W-1:0];
   assign rsp_handle = rsp_tdata[STATUS_W +: HANDLE_W];
   assign rsp_count  = rsp_tdata[STATUS_W + HANDLE_W +: CNT_W];
   assign req_beat   = req_tvalid && req_tready;

   // A stalled response beat holds
   `SKT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(rsp_tdata))
   // Each request beat is followed by a busy cycle
   `SKT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_beat, !req_tready)
   // Full status only with the table at capacity
   `SKT_ASSERT_NOW(a_full_count, clock, reset, rsp_tvalid && rsp_status == ST_FULL,
                   rsp_count == CNT_W'(CAPACITY))
   // A non-zero handle only comes with a hit
   `SKT_ASSERT_NOW(a_handle_hit, clock, reset, rsp_tvalid && rsp_handle != '0,
                   rsp_status == ST_OK)
   // Count never exceeds capacity
   `SKT_ASSERT_NOW(a_count_range, clock, reset, rsp_tvalid,
                   rsp_count <= CNT_W'(CAPACITY))

endmodule

bind sorted_key_table_top skt_checker #(
   .CAPACITY (CAPACITY)
) u_skt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
